// File: sv/tes_pkg.sv
package tes_pkg;

   localparam int COORD_BITS = 24;
   localparam int COEF_BITS  = 32;

   // exact widths of the intermediate terms
   localparam int EDGE_BITS = COORD_BITS + 1;
   localparam int NORM_BITS = 2 * EDGE_BITS + 1;
   localparam int DOT_BITS  = 2 * NORM_BITS + 2;
   localparam int DET_BITS  = NORM_BITS + EDGE_BITS + 2;
   localparam int DEN_BITS  = DET_BITS + 4;
   localparam int NUM_BITS  = DOT_BITS + 1;
   localparam int WORK_BITS = (NUM_BITS > DEN_BITS + COEF_BITS) ? NUM_BITS
                                                                : DEN_BITS + COEF_BITS;

   localparam int NUM_EDGES   = 5;
   localparam int NUM_NORMALS = 4;
   localparam int NUM_PAIRS   = 6;

   // edge vector slots
   localparam int E_JL = 0;   // d - b
   localparam int E_JK = 1;   // c - b
   localparam int E_IK = 2;   // c - a
   localparam int E_IL = 3;   // d - a
   localparam int E_IJ = 4;   // b - a

   // face normal slots, one per vertex
   localparam int N_A = 0;
   localparam int N_B = 1;
   localparam int N_C = 2;
   localparam int N_D = 3;

   // coupling slots
   localparam int K_AB = 0;
   localparam int K_AC = 1;
   localparam int K_AD = 2;
   localparam int K_BC = 3;
   localparam int K_BD = 4;
   localparam int K_CD = 5;

   localparam logic signed [COEF_BITS-1:0] COEF_MAX = {1'b0, {(COEF_BITS-1){1'b1}}};
   localparam logic signed [COEF_BITS-1:0] COEF_MIN = {1'b1, {(COEF_BITS-1){1'b0}}};

   typedef struct packed {
      logic signed [COORD_BITS-1:0] ax;
      logic signed [COORD_BITS-1:0] ay;
      logic signed [COORD_BITS-1:0] az;
      logic signed [COORD_BITS-1:0] bx;
      logic signed [COORD_BITS-1:0] by_coord;
      logic signed [COORD_BITS-1:0] bz;
      logic signed [COORD_BITS-1:0] cx;
      logic signed [COORD_BITS-1:0] cy;
      logic signed [COORD_BITS-1:0] cz;
      logic signed [COORD_BITS-1:0] dx;
      logic signed [COORD_BITS-1:0] dy;
      logic signed [COORD_BITS-1:0] dz;
   } req_type;

   typedef struct packed {
      logic signed [COEF_BITS-1:0] k_ab;
      logic signed [COEF_BITS-1:0] k_ac;
      logic signed [COEF_BITS-1:0] k_ad;
      logic signed [COEF_BITS-1:0] k_bc;
      logic signed [COEF_BITS-1:0] k_bd;
      logic signed [COEF_BITS-1:0] k_cd;
      logic signed [COEF_BITS-1:0] k_aa;
      logic signed [COEF_BITS-1:0] k_bb;
      logic signed [COEF_BITS-1:0] k_cc;
      logic signed [COEF_BITS-1:0] k_dd;
      logic                        degenerate;
   } rsp_type;

   typedef logic [NUM_EDGES-1:0][2:0][EDGE_BITS-1:0] edges_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// File: sv/tes_front.sv
module tes_front (
   input  tes_pkg::req_type   req,
   output tes_pkg::edges_type edges
);

   logic signed [tes_pkg::COORD_BITS-1:0] pt [4][3];

   assign pt[0][0] = req.ax;
   assign pt[0][1] = req.ay;
   assign pt[0][2] = req.az;
   assign pt[1][0] = req.bx;
   assign pt[1][1] = req.by_coord;
   assign pt[1][2] = req.bz;
   assign pt[2][0] = req.cx;
   assign pt[2][1] = req.cy;
   assign pt[2][2] = req.cz;
   assign pt[3][0] = req.dx;
   assign pt[3][1] = req.dy;
   assign pt[3][2] = req.dz;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         edges[tes_pkg::E_JL][c] = tes_pkg::EDGE_BITS'(pt[3][c]) - tes_pkg::EDGE_BITS'(pt[1][c]);
         edges[tes_pkg::E_JK][c] = tes_pkg::EDGE_BITS'(pt[2][c]) - tes_pkg::EDGE_BITS'(pt[1][c]);
         edges[tes_pkg::E_IK][c] = tes_pkg::EDGE_BITS'(pt[2][c]) - tes_pkg::EDGE_BITS'(pt[0][c]);
         edges[tes_pkg::E_IL][c] = tes_pkg::EDGE_BITS'(pt[3][c]) - tes_pkg::EDGE_BITS'(pt[0][c]);
         edges[tes_pkg::E_IJ][c] = tes_pkg::EDGE_BITS'(pt[1][c]) - tes_pkg::EDGE_BITS'(pt[0][c]);
      end
   end

endmodule

// File: sv/tes_queue.sv
module tes_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  logic [WIDTH-1:0]          push_data,
   input  logic                      pop,
   output logic [WIDTH-1:0]          pop_data,
   output tes_pkg::queue_status_type status
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    slot_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   assign wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      if (!push && pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_in;
         if (pop) rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_data;
   end

   assign pop_data     = slot_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_BITS'(DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

// File: sv/tes_mul.sv
module tes_mul #(
   parameter int A_BITS = 25,
   parameter int B_BITS = 25
) (
   input  logic                            clock,
   input  logic                            en,
   input  logic signed [A_BITS-1:0]        a,
   input  logic signed [B_BITS-1:0]        b,
   output logic signed [A_BITS+B_BITS-1:0] p
);

   localparam int AL = A_BITS / 2;
   localparam int AH = A_BITS - AL;
   localparam int BL = B_BITS / 2;
   localparam int BH = B_BITS - BL;
   localparam int PW = A_BITS + B_BITS;

   logic signed [AH-1:0] a_hi;
   logic signed [AL:0]   a_lo;
   logic signed [BH-1:0] b_hi;
   logic signed [BL:0]   b_lo;

   logic signed [AH+BH-1:0] hh_in, hh_ff;
   logic signed [AH+BL:0]   hl_in, hl_ff;
   logic signed [AL+BH:0]   lh_in, lh_ff;
   logic signed [AL+BL+1:0] ll_in, ll_ff;
   logic signed [PW-1:0]    p_in, p_ff;

   // low halves ride as non-negative signed operands
   assign a_hi = a[A_BITS-1:AL];
   assign a_lo = {1'b0, a[AL-1:0]};
   assign b_hi = b[B_BITS-1:BL];
   assign b_lo = {1'b0, b[BL-1:0]};

   assign hh_in = a_hi * b_hi;
   assign hl_in = a_hi * b_lo;
   assign lh_in = a_lo * b_hi;
   assign ll_in = a_lo * b_lo;

   assign p_in = (PW'(hh_ff) <<< (AL + BL)) + (PW'(hl_ff) <<< AL)
               + (PW'(lh_ff) <<< BL) + PW'(ll_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         hh_ff <= hh_in;
         hl_ff <= hl_in;
         lh_ff <= lh_in;
         ll_ff <= ll_in;
         p_ff  <= p_in;
      end
   end

   assign p = p_ff;

endmodule

// File: sv/tes_back.sv
module tes_back (
   input  logic                      clock,
   input  logic                      reset,
   input  tes_pkg::queue_status_type q_status,
   input  tes_pkg::edges_type        pop_data,
   output logic                      pop,
   input  logic                      rsp_stall,
   output logic                      rsp_valid,
   output tes_pkg::rsp_type          rsp_data
);

   localparam int EB  = tes_pkg::EDGE_BITS;
   localparam int NB  = tes_pkg::NORM_BITS;
   localparam int DTB = tes_pkg::DOT_BITS;
   localparam int DEB = tes_pkg::DET_BITS;
   localparam int DNB = tes_pkg::DEN_BITS;
   localparam int NMB = tes_pkg::NUM_BITS;
   localparam int WW  = tes_pkg::WORK_BITS;
   localparam int CB  = tes_pkg::COEF_BITS;
   localparam int NP  = tes_pkg::NUM_PAIRS;
   localparam int LAT = 12 + CB;

   function automatic logic signed [CB-1:0] diag(input logic signed [CB-1:0] p,
                                                 input logic signed [CB-1:0] q,
                                                 input logic signed [CB-1:0] r);
      logic signed [CB+2:0] s;
      s = -((CB+3)'(p) + (CB+3)'(q) + (CB+3)'(r));
      if (s > (CB+3)'(tes_pkg::COEF_MAX)) return tes_pkg::COEF_MAX;
      if (s < (CB+3)'(tes_pkg::COEF_MIN)) return tes_pkg::COEF_MIN;
      return CB'(s);
   endfunction

   logic           en;
   logic [LAT:1]   valid_ff;

   assign en  = !(valid_ff[LAT] && rsp_stall);
   assign pop = en && !q_status.empty;

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else if (en) valid_ff <= {valid_ff[LAT-1:1], pop};
   end

   // edge vectors
   tes_pkg::edges_type   e_s1;
   logic signed [EB-1:0] e1 [tes_pkg::NUM_EDGES][3];
   logic signed [EB-1:0] eil_s2 [3];
   logic signed [EB-1:0] eil_s3 [3];
   logic signed [EB-1:0] eil_s4 [3];

   always_ff @(posedge clock) begin
      if (en) begin
         e_s1 <= pop_data;
         for (int c = 0; c < 3; c++) begin
            eil_s2[c] <= e1[tes_pkg::E_IL][c];
            eil_s3[c] <= eil_s2[c];
            eil_s4[c] <= eil_s3[c];
         end
      end
   end

   for (genvar i = 0; i < tes_pkg::NUM_EDGES; i++) begin : g_edge
      for (genvar c = 0; c < 3; c++) begin : g_comp
         assign e1[i][c] = $signed(e_s1[i][c]);
      end
   end

   // face normals
   logic signed [NB-1:0] nrm_ff [tes_pkg::NUM_NORMALS][3];

   for (genvar n = 0; n < tes_pkg::NUM_NORMALS; n++) begin : g_norm
      localparam int UI = (n == tes_pkg::N_A) ? tes_pkg::E_JL :
                          (n == tes_pkg::N_B) ? tes_pkg::E_IK :
                          (n == tes_pkg::N_C) ? tes_pkg::E_IL : tes_pkg::E_IJ;
      localparam int VI = (n == tes_pkg::N_A) ? tes_pkg::E_JK :
                          (n == tes_pkg::N_B) ? tes_pkg::E_IL :
                          (n == tes_pkg::N_C) ? tes_pkg::E_IJ : tes_pkg::E_IK;
      for (genvar c = 0; c < 3; c++) begin : g_comp
         localparam int C1 = (c + 1) % 3;
         localparam int C2 = (c + 2) % 3;
         logic signed [2*EB-1:0] m0, m1;
         tes_mul #(.A_BITS(EB), .B_BITS(EB)) u_m0 (
            .clock(clock), .en(en), .a(e1[UI][C1]), .b(e1[VI][C2]), .p(m0));
         tes_mul #(.A_BITS(EB), .B_BITS(EB)) u_m1 (
            .clock(clock), .en(en), .a(e1[UI][C2]), .b(e1[VI][C1]), .p(m1));
         always_ff @(posedge clock) begin
            if (en) nrm_ff[n][c] <= NB'(m0) - NB'(m1);
         end
      end
   end

   // normal dot products and determinant
   logic signed [DTB-1:0] dot_ff [NP];
   logic signed [DEB-1:0] det_ff;

   for (genvar k = 0; k < NP; k++) begin : g_pair
      localparam int PI = (k < 3) ? tes_pkg::N_A : (k < 5) ? tes_pkg::N_B : tes_pkg::N_C;
      localparam int PJ = (k == 0) ? tes_pkg::N_B :
                          (k == 1 || k == 3) ? tes_pkg::N_C : tes_pkg::N_D;
      logic signed [2*NB-1:0] pd [3];
      for (genvar c = 0; c < 3; c++) begin : g_comp
         tes_mul #(.A_BITS(NB), .B_BITS(NB)) u_m (
            .clock(clock), .en(en), .a(nrm_ff[PI][c]), .b(nrm_ff[PJ][c]), .p(pd[c]));
      end
      always_ff @(posedge clock) begin
         if (en) dot_ff[k] <= DTB'(pd[0]) + DTB'(pd[1]) + DTB'(pd[2]);
      end
   end

   logic signed [NB+EB-1:0] pv [3];
   for (genvar c = 0; c < 3; c++) begin : g_det
      tes_mul #(.A_BITS(NB), .B_BITS(EB)) u_m (
         .clock(clock), .en(en), .a(nrm_ff[tes_pkg::N_D][c]), .b(eil_s4[c]), .p(pv[c]));
   end

   always_ff @(posedge clock) begin
      if (en) det_ff <= DEB'(pv[0]) + DEB'(pv[1]) + DEB'(pv[2]);
   end

   // magnitudes, then rounding numerator and doubled denominator
   logic           zero_s8;
   logic [DEB-1:0] absdet_s8;
   logic [DTB-1:0] mag_s8 [NP];
   logic [NP-1:0]  neg_s8;
   logic           zero_s9;
   logic [DNB-1:0] den2_s9;
   logic [NMB-1:0] num_s9 [NP];
   logic [NP-1:0]  neg_s9;

   always_ff @(posedge clock) begin
      if (en) begin
         zero_s8   <= (det_ff == '0);
         absdet_s8 <= det_ff[DEB-1] ? DEB'(-det_ff) : DEB'(det_ff);
         for (int k = 0; k < NP; k++) begin
            neg_s8[k] <= dot_ff[k][DTB-1];
            mag_s8[k] <= dot_ff[k][DTB-1] ? DTB'(-dot_ff[k]) : DTB'(dot_ff[k]);
         end
         zero_s9 <= zero_s8;
         neg_s9  <= neg_s8;
         // 2 * 6|det|, and 2|n| + 6|det| for round half away
         den2_s9 <= (DNB'(absdet_s8) << 3) + (DNB'(absdet_s8) << 2);
         for (int k = 0; k < NP; k++) begin
            num_s9[k] <= (NMB'(mag_s8[k]) << 1) + (NMB'(absdet_s8) << 2)
                       + (NMB'(absdet_s8) << 1);
         end
      end
   end

   // restoring divider, one quotient bit per stage
   logic [WW-1:0]  rem_ff  [0:CB-1][NP];
   logic [DNB-1:0] den_ff  [0:CB-1];
   logic [CB-1:0]  quo_ff  [1:CB][NP];
   logic [NP-1:0]  neg_ff  [0:CB];
   logic [NP-1:0]  over_ff [0:CB];
   logic           zero_ff [0:CB];

   always_ff @(posedge clock) begin
      if (en) begin
         den_ff[0]  <= den2_s9;
         neg_ff[0]  <= neg_s9;
         zero_ff[0] <= zero_s9;
         for (int k = 0; k < NP; k++) begin
            rem_ff[0][k]  <= WW'(num_s9[k]);
            over_ff[0][k] <= WW'(num_s9[k]) >= (WW'(den2_s9) << CB);
         end
      end
   end

   for (genvar j = 1; j <= CB; j++) begin : g_div
      localparam int SH = CB - j;
      logic [WW-1:0] dsh;
      assign dsh = WW'(den_ff[j-1]) << SH;

      always_ff @(posedge clock) begin
         if (en) begin
            neg_ff[j]  <= neg_ff[j-1];
            over_ff[j] <= over_ff[j-1];
            zero_ff[j] <= zero_ff[j-1];
         end
      end

      if (j < CB) begin : g_den
         always_ff @(posedge clock) begin
            if (en) den_ff[j] <= den_ff[j-1];
         end
      end

      for (genvar k = 0; k < NP; k++) begin : g_lane
         logic [WW:0] diff;
         logic        qbit;
         assign diff = {1'b0, rem_ff[j-1][k]} - {1'b0, dsh};
         assign qbit = !diff[WW];
         if (j == 1) begin : g_first
            always_ff @(posedge clock) begin
               if (en) quo_ff[j][k] <= {{(CB-1){1'b0}}, qbit};
            end
         end else begin : g_next
            always_ff @(posedge clock) begin
               if (en) quo_ff[j][k] <= {quo_ff[j-1][k][CB-2:0], qbit};
            end
         end
         if (j < CB) begin : g_rem
            always_ff @(posedge clock) begin
               if (en) rem_ff[j][k] <= qbit ? diff[WW-1:0] : rem_ff[j-1][k];
            end
         end
      end
   end

   // sign and saturation of the couplings
   logic signed [CB-1:0] cpl_ff [NP];
   logic                 zero_sat_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         zero_sat_ff <= zero_ff[CB];
         for (int k = 0; k < NP; k++) begin
            if (over_ff[CB][k] || quo_ff[CB][k][CB-1]) begin
               cpl_ff[k] <= neg_ff[CB][k] ? tes_pkg::COEF_MIN : tes_pkg::COEF_MAX;
            end else begin
               cpl_ff[k] <= neg_ff[CB][k] ? $signed(-quo_ff[CB][k]) : $signed(quo_ff[CB][k]);
            end
         end
      end
   end

   // diagonals and output register
   tes_pkg::rsp_type out_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (zero_sat_ff) begin
            out_ff <= '{degenerate: 1'b1, default: '0};
         end else begin
            out_ff.k_ab <= cpl_ff[tes_pkg::K_AB];
            out_ff.k_ac <= cpl_ff[tes_pkg::K_AC];
            out_ff.k_ad <= cpl_ff[tes_pkg::K_AD];
            out_ff.k_bc <= cpl_ff[tes_pkg::K_BC];
            out_ff.k_bd <= cpl_ff[tes_pkg::K_BD];
            out_ff.k_cd <= cpl_ff[tes_pkg::K_CD];
            out_ff.k_aa <= diag(cpl_ff[tes_pkg::K_AB], cpl_ff[tes_pkg::K_AC],
                                cpl_ff[tes_pkg::K_AD]);
            out_ff.k_bb <= diag(cpl_ff[tes_pkg::K_AB], cpl_ff[tes_pkg::K_BC],
                                cpl_ff[tes_pkg::K_BD]);
            out_ff.k_cc <= diag(cpl_ff[tes_pkg::K_AC], cpl_ff[tes_pkg::K_BC],
                                cpl_ff[tes_pkg::K_CD]);
            out_ff.k_dd <= diag(cpl_ff[tes_pkg::K_AD], cpl_ff[tes_pkg::K_BD],
                                cpl_ff[tes_pkg::K_CD]);
            out_ff.degenerate <= 1'b0;
         end
      end
   end

   assign rsp_valid = valid_ff[LAT];
   assign rsp_data  = out_ff;

endmodule

// File: sv/tetra_element_stiffness_core.sv
// Linear tetrahedral element stiffness kernel. Each req beat carries the four
// vertices of one tetrahedron (Q8.16); each rsp beat returns the six couplings
// and four diagonals (Q16.16, saturated) plus a degenerate flag for a zero
// determinant. Fully pipelined, it takes one beat per cycle unless rsp_stall
// or a full input queue holds it; from the queue a beat passes the edge,
// normal, dot, rounding and restoring-divider (one quotient bit per stage)
// registers, then saturation and output. While a result waits on rsp_stall the
// whole back pipeline holds; edge vectors are formed on entry and held in a
// small queue, so up to QUEUE_DEPTH input beats are buffered during that wait.
module tetra_element_stiffness_core #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tes_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tes_pkg::rsp_type rsp_data
);

   tes_pkg::edges_type        push_edges;
   tes_pkg::edges_type        pop_edges;
   tes_pkg::queue_status_type q_status;
   logic                      push;
   logic                      pop;

   assign req_stall = q_status.full;
   assign push      = req_valid && !req_stall;

   tes_front u_front (
      .req   (req_data),
      .edges (push_edges)
   );

   tes_queue #(
      .WIDTH ($bits(tes_pkg::edges_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_edges),
      .pop       (pop),
      .pop_data  (pop_edges),
      .status    (q_status)
   );

   tes_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .pop_data  (pop_edges),
      .pop       (pop),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   a_reset_clears_out: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high right after reset");

   a_degenerate_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.degenerate |->
         rsp_data.k_ab == '0 && rsp_data.k_ac == '0 && rsp_data.k_ad == '0 &&
         rsp_data.k_bc == '0 && rsp_data.k_bd == '0 && rsp_data.k_cd == '0 &&
         rsp_data.k_aa == '0 && rsp_data.k_bb == '0 && rsp_data.k_cc == '0 &&
         rsp_data.k_dd == '0)
      else $error("degenerate beat with nonzero coefficients");

   a_stall_means_backlog: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> !q_status.empty)
      else $error("input stalled with an empty queue");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      q_status.empty |-> !pop)
      else $error("queue popped while empty");

endmodule
